[hw/rtl/cchm_pkg.sv]
package cchm_pkg;

    // Default sizing
    localparam int CELLS_DEF   = 1024;
    localparam int SHOWERS_DEF = 8;
    localparam int LAYERS_DEF  = 50;

    // Number of z ranges in the layer table
    localparam int TABLE_RANGES = 50;
    localparam int Z_TOL        = 1;

    // floor(a / 10000) = (a * RECIP) >> RECIP_SHIFT for any a below 2^24
    localparam logic [23:0] RECIP       = 24'd13743896;
    localparam int          RECIP_SHIFT = 37;
    localparam logic [23:0] HALF_CM     = 24'd5000;

    localparam logic [47:0] SUM_MAX = 48'hFFFF_FFFF_FFFF;

    // Result status codes
    typedef enum logic [2:0] {
        ST_MERGED = 3'd0,
        ST_ZERO   = 3'd1,
        ST_NOLAY  = 3'd2,
        ST_FULL   = 3'd3,
        ST_HIT    = 3'd4,
        ST_EMPTY  = 3'd5
    } status_t;

    // Item kind on the input side
    localparam logic OP_DEPOSIT = 1'b0;
    localparam logic OP_POP     = 1'b1;

    // Layer boundaries in z, 1e-4 cm
    function automatic logic signed [24:0] zedge(input logic [5:0] idx);
        logic signed [24:0] v;
        unique case (idx)
            6'd0:  v = 25'sd3196660;
            6'd1:  v = 25'sd3221660;
            6'd2:  v = 25'sd3246650;
            6'd3:  v = 25'sd3271640;
            6'd4:  v = 25'sd3296640;
            6'd5:  v = 25'sd3321650;
            6'd6:  v = 25'sd3346650;
            6'd7:  v = 25'sd3371650;
            6'd8:  v = 25'sd3396660;
            6'd9:  v = 25'sd3421660;
            6'd10: v = 25'sd3446660;
            6'd11: v = 25'sd3471650;
            6'd12: v = 25'sd3496650;
            6'd13: v = 25'sd3521650;
            6'd14: v = 25'sd3546660;
            6'd15: v = 25'sd3571660;
            6'd16: v = 25'sd3596660;
            6'd17: v = 25'sd3621660;
            6'd18: v = 25'sd3646650;
            6'd19: v = 25'sd3671660;
            6'd20: v = 25'sd3696660;
            6'd21: v = 25'sd3721660;
            6'd22: v = 25'sd3746660;
            6'd23: v = 25'sd3771650;
            6'd24: v = 25'sd3796650;
            6'd25: v = 25'sd3821650;
            6'd26: v = 25'sd3846650;
            6'd27: v = 25'sd3871650;
            6'd28: v = 25'sd3914160;
            6'd29: v = 25'sd3969160;
            6'd30: v = 25'sd4019150;
            6'd31: v = 25'sd4069160;
            6'd32: v = 25'sd4119160;
            6'd33: v = 25'sd4169160;
            6'd34: v = 25'sd4219160;
            6'd35: v = 25'sd4269160;
            6'd36: v = 25'sd4319160;
            6'd37: v = 25'sd4369160;
            6'd38: v = 25'sd4419160;
            6'd39: v = 25'sd4469160;
            6'd40: v = 25'sd4519160;
            6'd41: v = 25'sd4569150;
            6'd42: v = 25'sd4619150;
            6'd43: v = 25'sd4669160;
            6'd44: v = 25'sd4719160;
            6'd45: v = 25'sd4769160;
            6'd46: v = 25'sd4819140;
            6'd47: v = 25'sd4869140;
            6'd48: v = 25'sd4919160;
            6'd49: v = 25'sd4969180;
            6'd50: v = 25'sd5019220;
            default: v = 25'sd0;
        endcase
        return v;
    endfunction

    // Add with saturation at 2^48 - 1
    function automatic logic [47:0] sat_add(input logic [47:0] a, input logic [31:0] b);
        logic [48:0] s;
        s = {1'b0, a} + {17'd0, b};
        return s[48] ? SUM_MAX : s[47:0];
    endfunction

endpackage

[hw/rtl/calorimeter_cell_hit_merger.sv]
// Sequence: a deposit tries the layer ranges in turn (L layers), walks the N stored cell
//   keys and then the S showers of the cell, or stops when no layer matches; a pop scans
//   the showers and divides unless no division is needed; status-only results skip these steps.
// Throughput: one word at a time; tready is high only in the idle state.
//   The cell key walk over the cell store (one cell a cycle) sets the worst case.
// Reset: rst_n clears the cell count, drain pointer, sequencer and output valid;
//   the cell and shower stores hold no reset value and need no clearing pass.
module calorimeter_cell_hit_merger #(
    parameter int CELLS            = cchm_pkg::CELLS_DEF,
    parameter int SHOWERS_PER_CELL = cchm_pkg::SHOWERS_DEF,
    parameter int LAYERS           = cchm_pkg::LAYERS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // z_pos[23:0] center_x[47:24] center_y[71:48] center_z[95:72]
    // energy[127:96] track_id[158:128] shower_id[189:159], zero fill
    input  logic [191:0] s_axis_tdata,
    // op
    input  logic         s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // hit_layer[5:0] hit_x[29:6] hit_y[53:30] hit_z[77:54] hit_energy[125:78]
    // first_track[156:126] dominant_shower[188:157] purity[205:189]
    // shower_overflow[206], zero fill
    output logic [207:0] m_axis_tdata,
    // status
    output logic [2:0]   m_axis_tuser,
    // last_hit
    output logic         m_axis_tlast
);

    localparam int CW  = $clog2(CELLS + 1);
    localparam int IW  = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int SNW = $clog2(SHOWERS_PER_CELL + 1);
    localparam int SIW = (SHOWERS_PER_CELL > 1) ? $clog2(SHOWERS_PER_CELL) : 1;
    localparam int SD  = CELLS * SHOWERS_PER_CELL;
    localparam int SAW = (SD > 1) ? $clog2(SD) : 1;
    localparam int NL  = (LAYERS < cchm_pkg::TABLE_RANGES) ? LAYERS : cchm_pkg::TABLE_RANGES;
    localparam logic [5:0]  NL_LAST = 6'(NL - 1);
    localparam logic [CW-1:0] CELLS_C = CW'(CELLS);
    localparam logic [SNW-1:0] SPC_C = SNW'(SHOWERS_PER_CELL);

    typedef enum logic [3:0] {
        S_IDLE, S_LAYER, S_RND_X, S_RND_Y, S_RND_K, S_SRCH, S_CELL_RD, S_SHW,
        S_POP_RD, S_POP_CELL, S_POP_SCAN, S_DIV, S_FINISH
    } state_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [5:0]  layer;
        logic [23:0] x;
        logic [23:0] y;
        logic [23:0] z;
        logic [47:0] energy;
        logic [30:0] trk;
        logic [31:0] dom;
        logic [16:0] pur;
        logic        ovf;
        logic        last;
    } res_t;

    state_t state_reg;
    res_t   res_reg, out_reg;
    logic   out_valid_reg;

    logic [CW-1:0]  cells_used_reg, drain_reg, scan_reg;
    logic [IW-1:0]  cur_cell_reg, cmp_idx_reg;
    logic           cmp_valid_reg;
    logic [SNW-1:0] n_reg, sscan_reg;
    logic [SIW-1:0] scmp_idx_reg;
    logic           scmp_valid_reg;
    logic [5:0]     lay_reg;
    logic [10:0]    kx_reg;
    logic [27:0]    key_reg;
    logic [47:0]    mul_reg;
    logic [47:0]    max_reg, total_reg, rem_reg;
    logic [15:0]    q_reg;
    logic [4:0]     div_cnt_reg;

    logic signed [23:0] z_reg, cx_reg, cy_reg, cz_reg;
    logic [31:0] e_reg;
    logic [30:0] trk_reg, shw_reg;

    // Stores
    logic [27:0]    key_mem   [CELLS];
    logic [23:0]    cx_mem    [CELLS];
    logic [23:0]    cy_mem    [CELLS];
    logic [23:0]    cz_mem    [CELLS];
    logic [47:0]    esum_mem  [CELLS];
    logic [30:0]    trk_mem   [CELLS];
    logic [SNW-1:0] cnt_mem   [CELLS];
    logic           ovf_mem   [CELLS];
    logic [30:0]    shid_mem  [SD];
    logic [47:0]    shsum_mem [SD];

    logic [27:0]    key_rd;
    logic [23:0]    cx_rd, cy_rd, cz_rd;
    logic [47:0]    esum_rd, shsum_rd;
    logic [30:0]    trk_rd, shid_rd;
    logic [SNW-1:0] cnt_rd;
    logic           ovf_rd;

    logic [IW-1:0]  cell_raddr, cell_waddr;
    logic           newc_we, esum_we, cnt_we, ovf_we, shid_we, shsum_we;
    logic [47:0]    esum_wd, shsum_wd;
    logic [SNW-1:0] cnt_wd;
    logic           ovf_wd;
    logic [SAW-1:0] sh_base, sh_raddr, sh_waddr;

    logic           key_match, sh_match, srch_miss, shw_done;
    logic signed [24:0] z_ext, lo_edge, hi_edge;
    logic           in_layer;
    logic [23:0]    ax, ay, mul_a;
    logic [10:0]    q11;
    logic [10:0]    rnd_x, rnd_y;
    logic [48:0]    rem_sh;
    logic           accept;

    assign accept        = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == S_IDLE);

    // Layer range test for the current table entry
    assign z_ext    = 25'(z_reg);
    assign lo_edge  = cchm_pkg::zedge(lay_reg) - 25'(cchm_pkg::Z_TOL);
    assign hi_edge  = cchm_pkg::zedge(lay_reg + 6'd1) + 25'(cchm_pkg::Z_TOL);
    assign in_layer = (z_ext >= lo_edge) && (z_ext <= hi_edge);

    // Shared reciprocal multiplier for rounding to whole cm
    assign ax    = (cx_reg[23] ? (~cx_reg + 24'd1) : cx_reg) + cchm_pkg::HALF_CM;
    assign ay    = (cy_reg[23] ? (~cy_reg + 24'd1) : cy_reg) + cchm_pkg::HALF_CM;
    assign mul_a = (state_reg == S_RND_X) ? ax : ay;
    assign q11   = mul_reg[47:cchm_pkg::RECIP_SHIFT];
    assign rnd_x = cx_reg[23] ? (~q11 + 11'd1) : q11;
    assign rnd_y = cy_reg[23] ? (~q11 + 11'd1) : q11;

    assign key_match = cmp_valid_reg && (key_rd == key_reg);
    assign srch_miss = !key_match && (scan_reg >= cells_used_reg);
    assign sh_match  = scmp_valid_reg && (shid_rd == shw_reg);
    assign shw_done  = !sh_match && (sscan_reg >= n_reg);
    assign sh_base   = SAW'(cur_cell_reg) * SAW'(SHOWERS_PER_CELL);
    assign sh_raddr  = sh_base + SAW'(sscan_reg[SIW-1:0]);
    assign rem_sh    = {rem_reg, 1'b0};

    // Store address and write control
    always_comb
    begin
        cell_raddr = cur_cell_reg;
        cell_waddr = cur_cell_reg;
        newc_we    = 1'b0;
        esum_we    = 1'b0;
        esum_wd    = cchm_pkg::sat_add(esum_rd, e_reg);
        cnt_we     = 1'b0;
        cnt_wd     = n_reg + SNW'(1);
        ovf_we     = 1'b0;
        ovf_wd     = 1'b1;
        shid_we    = 1'b0;
        shsum_we   = 1'b0;
        shsum_wd   = {16'd0, e_reg};
        sh_waddr   = sh_base + SAW'(n_reg[SIW-1:0]);
        unique case (state_reg)
            S_SRCH:
            begin
                cell_raddr = key_match ? cmp_idx_reg : scan_reg[IW-1:0];
                if (srch_miss && (cells_used_reg < CELLS_C))
                begin
                    cell_waddr = cells_used_reg[IW-1:0];
                    newc_we    = 1'b1;
                    esum_we    = 1'b1;
                    esum_wd    = {16'd0, e_reg};
                    cnt_we     = 1'b1;
                    cnt_wd     = SNW'(1);
                    ovf_we     = 1'b1;
                    ovf_wd     = 1'b0;
                    shid_we    = 1'b1;
                    shsum_we   = 1'b1;
                    sh_waddr   = SAW'(cells_used_reg[IW-1:0]) * SAW'(SHOWERS_PER_CELL);
                end
            end
            S_CELL_RD:
            begin
                esum_we = 1'b1;
            end
            S_SHW:
            begin
                if (sh_match)
                begin
                    shsum_we = 1'b1;
                    shsum_wd = cchm_pkg::sat_add(shsum_rd, e_reg);
                    sh_waddr = sh_base + SAW'(scmp_idx_reg);
                end
                else if (shw_done)
                begin
                    if (n_reg < SPC_C)
                    begin
                        shid_we  = 1'b1;
                        shsum_we = 1'b1;
                        cnt_we   = 1'b1;
                    end
                    else
                    begin
                        ovf_we = 1'b1;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    // Cell stores
    always_ff @(posedge clk)
    begin
        if (newc_we)
        begin
            key_mem[cell_waddr] <= key_reg;
            cx_mem[cell_waddr]  <= cx_reg;
            cy_mem[cell_waddr]  <= cy_reg;
            cz_mem[cell_waddr]  <= cz_reg;
            trk_mem[cell_waddr] <= trk_reg;
        end
        key_rd <= key_mem[cell_raddr];
        cx_rd  <= cx_mem[cell_raddr];
        cy_rd  <= cy_mem[cell_raddr];
        cz_rd  <= cz_mem[cell_raddr];
        trk_rd <= trk_mem[cell_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (esum_we)
        begin
            esum_mem[cell_waddr] <= esum_wd;
        end
        esum_rd <= esum_mem[cell_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (cnt_we)
        begin
            cnt_mem[cell_waddr] <= cnt_wd;
        end
        cnt_rd <= cnt_mem[cell_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (ovf_we)
        begin
            ovf_mem[cell_waddr] <= ovf_wd;
        end
        ovf_rd <= ovf_mem[cell_raddr];
    end

    // Shower stores
    always_ff @(posedge clk)
    begin
        if (shid_we)
        begin
            shid_mem[sh_waddr] <= shw_reg;
        end
        shid_rd <= shid_mem[sh_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (shsum_we)
        begin
            shsum_mem[sh_waddr] <= shsum_wd;
        end
        shsum_rd <= shsum_mem[sh_raddr];
    end

    // Sequencer, counters and output word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            out_valid_reg  <= 1'b0;
            cells_used_reg <= '0;
            drain_reg      <= '0;
            cmp_valid_reg  <= 1'b0;
            scmp_valid_reg <= 1'b0;
            res_reg        <= '0;
        end
        else
        begin
            // Drop the output word once taken, unless a new one replaces it
            if (out_valid_reg && m_axis_tready && (state_reg != S_FINISH))
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        z_reg        <= s_axis_tdata[23:0];
                        cx_reg       <= s_axis_tdata[47:24];
                        cy_reg       <= s_axis_tdata[71:48];
                        cz_reg       <= s_axis_tdata[95:72];
                        e_reg        <= s_axis_tdata[127:96];
                        trk_reg      <= s_axis_tdata[158:128];
                        shw_reg      <= s_axis_tdata[189:159];
                        lay_reg      <= '0;
                        cur_cell_reg <= drain_reg[IW-1:0];
                        if (s_axis_tuser == cchm_pkg::OP_POP)
                        begin
                            if (drain_reg >= cells_used_reg)
                            begin
                                res_reg.status <= cchm_pkg::ST_EMPTY;
                                state_reg      <= S_FINISH;
                            end
                            else
                            begin
                                res_reg.status <= cchm_pkg::ST_HIT;
                                state_reg      <= S_POP_RD;
                            end
                        end
                        else if (s_axis_tdata[127:96] == 32'd0)
                        begin
                            res_reg.status <= cchm_pkg::ST_ZERO;
                            state_reg      <= S_FINISH;
                        end
                        else
                        begin
                            res_reg.status <= cchm_pkg::ST_MERGED;
                            state_reg      <= S_LAYER;
                        end
                    end
                end
                // Try one layer range a cycle
                S_LAYER:
                begin
                    if (in_layer)
                    begin
                        lay_reg   <= lay_reg + 6'd1;
                        state_reg <= S_RND_X;
                    end
                    else if (lay_reg == NL_LAST)
                    begin
                        res_reg.status <= cchm_pkg::ST_NOLAY;
                        state_reg      <= S_FINISH;
                    end
                    else
                    begin
                        lay_reg <= lay_reg + 6'd1;
                    end
                end
                S_RND_X:
                begin
                    mul_reg   <= mul_a * cchm_pkg::RECIP;
                    state_reg <= S_RND_Y;
                end
                S_RND_Y:
                begin
                    kx_reg    <= rnd_x;
                    mul_reg   <= mul_a * cchm_pkg::RECIP;
                    state_reg <= S_RND_K;
                end
                S_RND_K:
                begin
                    key_reg       <= {lay_reg, kx_reg, rnd_y};
                    scan_reg      <= '0;
                    cmp_valid_reg <= 1'b0;
                    state_reg     <= S_SRCH;
                end
                // Walk the cell keys, one read issued and one compared per cycle
                S_SRCH:
                begin
                    if (key_match)
                    begin
                        cur_cell_reg  <= cmp_idx_reg;
                        cmp_valid_reg <= 1'b0;
                        state_reg     <= S_CELL_RD;
                    end
                    else if (srch_miss)
                    begin
                        cmp_valid_reg <= 1'b0;
                        if (cells_used_reg >= CELLS_C)
                        begin
                            res_reg.status <= cchm_pkg::ST_FULL;
                        end
                        else
                        begin
                            cells_used_reg <= cells_used_reg + CW'(1);
                        end
                        state_reg <= S_FINISH;
                    end
                    else
                    begin
                        cmp_idx_reg   <= scan_reg[IW-1:0];
                        cmp_valid_reg <= 1'b1;
                        scan_reg      <= scan_reg + CW'(1);
                    end
                end
                S_CELL_RD:
                begin
                    n_reg          <= cnt_rd;
                    sscan_reg      <= '0;
                    scmp_valid_reg <= 1'b0;
                    state_reg      <= S_SHW;
                end
                // Walk the shower list of the cell
                S_SHW:
                begin
                    if (sh_match || shw_done)
                    begin
                        scmp_valid_reg <= 1'b0;
                        if (!sh_match && (n_reg >= SPC_C))
                        begin
                            res_reg.ovf <= 1'b1;
                        end
                        state_reg <= S_FINISH;
                    end
                    else
                    begin
                        scmp_idx_reg   <= sscan_reg[SIW-1:0];
                        scmp_valid_reg <= 1'b1;
                        sscan_reg      <= sscan_reg + SNW'(1);
                    end
                end
                S_POP_RD:
                begin
                    state_reg <= S_POP_CELL;
                end
                // Take the cell fields and advance the drain pointer
                S_POP_CELL:
                begin
                    res_reg.layer  <= key_rd[27:22];
                    res_reg.x      <= cx_rd;
                    res_reg.y      <= cy_rd;
                    res_reg.z      <= cz_rd;
                    res_reg.energy <= esum_rd;
                    res_reg.trk    <= trk_rd;
                    res_reg.ovf    <= ovf_rd;
                    res_reg.dom    <= '1;
                    total_reg      <= esum_rd;
                    max_reg        <= '0;
                    n_reg          <= cnt_rd;
                    sscan_reg      <= '0;
                    scmp_valid_reg <= 1'b0;
                    if (drain_reg + CW'(1) >= cells_used_reg)
                    begin
                        res_reg.last   <= 1'b1;
                        cells_used_reg <= '0;
                        drain_reg      <= '0;
                    end
                    else
                    begin
                        drain_reg <= drain_reg + CW'(1);
                    end
                    state_reg <= S_POP_SCAN;
                end
                // Find the first strictly largest shower sum
                S_POP_SCAN:
                begin
                    if (scmp_valid_reg && (shsum_rd > max_reg))
                    begin
                        max_reg     <= shsum_rd;
                        res_reg.dom <= {1'b0, shid_rd};
                    end
                    if (sscan_reg >= n_reg)
                    begin
                        scmp_valid_reg <= 1'b0;
                        state_reg      <= S_DIV;
                        div_cnt_reg    <= '0;
                        q_reg          <= '0;
                        rem_reg        <= (scmp_valid_reg && (shsum_rd > max_reg))
                                          ? shsum_rd : max_reg;
                    end
                    else
                    begin
                        scmp_valid_reg <= 1'b1;
                        sscan_reg      <= sscan_reg + SNW'(1);
                    end
                end
                // Long division, one quotient bit a cycle
                S_DIV:
                begin
                    if ((max_reg == 48'd0) || (total_reg == 48'd0))
                    begin
                        res_reg.pur <= '0;
                        state_reg   <= S_FINISH;
                    end
                    else if (max_reg >= total_reg)
                    begin
                        res_reg.pur <= 17'h10000;
                        state_reg   <= S_FINISH;
                    end
                    else if (div_cnt_reg == 5'd16)
                    begin
                        res_reg.pur <= {1'b0, q_reg};
                        state_reg   <= S_FINISH;
                    end
                    else
                    begin
                        if (rem_sh >= {1'b0, total_reg})
                        begin
                            rem_reg <= 48'(rem_sh - {1'b0, total_reg});
                            q_reg   <= {q_reg[14:0], 1'b1};
                        end
                        else
                        begin
                            rem_reg <= rem_sh[47:0];
                            q_reg   <= {q_reg[14:0], 1'b0};
                        end
                        div_cnt_reg <= div_cnt_reg + 5'd1;
                    end
                end
                // Hand the word to the output register once it is free
                S_FINISH:
                begin
                    if (!out_valid_reg || m_axis_tready)
                    begin
                        out_reg       <= res_reg;
                        res_reg       <= '0;
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_reg.status;
    assign m_axis_tlast  = out_reg.last;
    assign m_axis_tdata  = {1'b0, out_reg.ovf, out_reg.pur, out_reg.dom, out_reg.trk,
                            out_reg.energy, out_reg.z, out_reg.y, out_reg.x, out_reg.layer};

`ifndef SYNTHESIS
    a_drain_bound: assert property (@(posedge clk) disable iff (!rst_n)
        drain_reg <= cells_used_reg)
        else $error("drain pointer past cell count");
    a_cells_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cells_used_reg <= CELLS_C)
        else $error("cell count past capacity");
    a_last_is_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tlast) |-> (m_axis_tuser == cchm_pkg::ST_HIT))
        else $error("last flag on a word that is not a hit");
    a_shw_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_SHW) || (state_reg == S_POP_SCAN)) |-> (sscan_reg <= n_reg))
        else $error("shower scan past list length");
    a_purity_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[205:189] <= 17'h10000))
        else $error("purity above one");
`endif

endmodule
